@@ design/assert_macros.svh @@
// shared assertion macros for the escape encoder checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define UEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define UEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/uep_pkg.sv @@
package uep_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] PERCENT_CHAR = 8'h25;
  localparam logic [7:0] HIGH_START   = 8'h7f;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_beat_t;

  // one decided byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       run_last;
    logic       string_end;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_alnum_or_high(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h30 && c <= 8'h39) || (c >= HIGH_START);
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

endpackage

@@ design/uep_front.sv @@
module uep_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uep_pkg::in_beat_t   in_data,
  input  uep_pkg::q_status_t  q_status,
  output logic                push_valid,
  output uep_pkg::q_entry_t   push_entry
);

  logic [7:0] older_r, older_nxt;
  logic [7:0] newer_r, newer_nxt;
  logic [1:0] held_r, held_nxt;
  logic       flush_r, flush_nxt;
  logic       accept;
  logic       full_win;

  assign full_win = held_r[1];
  assign in_ready = !flush_r && !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    held_nxt   = held_r;
    flush_nxt  = flush_r;
    push_valid = 1'b0;
    push_entry = '0;
    if (flush_r) begin
      // drain the window, one byte per cycle while the queue has room, no lookahead left
      if (!q_status.full) begin
        push_valid            = 1'b1;
        push_entry.data       = older_r;
        push_entry.esc        = !uep_pkg::is_alnum_or_high(older_r);
        push_entry.run_last   = (held_r == 2'd1);
        push_entry.string_end = (held_r == 2'd1);
        if (held_r == 2'd1) begin
          held_nxt  = 2'd0;
          flush_nxt = 1'b0;
          older_nxt = '0;
          newer_nxt = '0;
        end else begin
          older_nxt = newer_r;
          held_nxt  = 2'd1;
        end
      end
    end else if (accept) begin
      if (full_win) begin
        push_valid          = 1'b1;
        push_entry.data     = older_r;
        push_entry.esc      = !(uep_pkg::is_alnum_or_high(older_r) ||
                                (older_r == uep_pkg::PERCENT_CHAR &&
                                 uep_pkg::is_hex_digit(newer_r) &&
                                 uep_pkg::is_hex_digit(in_data.in_byte)));
        push_entry.run_last = !in_data.in_last;
        older_nxt           = newer_r;
        newer_nxt           = in_data.in_byte;
        held_nxt            = 2'd2;
      end else if (held_r == 2'd1) begin
        newer_nxt = in_data.in_byte;
        held_nxt  = 2'd2;
      end else begin
        older_nxt = in_data.in_byte;
        held_nxt  = 2'd1;
      end
      flush_nxt = in_data.in_last;
    end
  end

  always_ff @(posedge clk) begin
    older_r <= older_nxt;
    newer_r <= newer_nxt;
    if (!rst_n) begin
      held_r  <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

@@ design/uep_queue.sv @@
module uep_queue #(
  parameter int DEPTH = uep_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  uep_pkg::q_entry_t   push_entry,
  input  logic                pop,
  output uep_pkg::q_entry_t   head,
  output uep_pkg::q_status_t  q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uep_pkg::q_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_status.full  = (count_r == CW'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign head           = slot_r[rd_ptr_r];

  assign do_push = push_valid && !q_status.full;
  assign do_pop  = pop && !q_status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ design/uep_back.sv @@
module uep_back (
  input  logic                clk,
  input  logic                rst_n,
  input  uep_pkg::q_entry_t   head,
  input  uep_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output uep_pkg::out_beat_t  out_data
);

  logic [1:0]          phase_r, phase_nxt;
  logic                valid_r, valid_nxt;
  uep_pkg::out_beat_t  beat_r, beat_nxt;
  logic                advance;
  logic                final_byte;
  logic [7:0]          sel_byte;

  assign advance = !q_status.empty && (!valid_r || out_ready);

  always_comb begin
    final_byte = 1'b1;
    sel_byte   = head.data;
    if (head.esc) begin
      final_byte = (phase_r == 2'd2);
      case (phase_r)
        2'd0:    sel_byte = uep_pkg::PERCENT_CHAR;
        2'd1:    sel_byte = uep_pkg::hex_char(head.data[7:4]);
        default: sel_byte = uep_pkg::hex_char(head.data[3:0]);
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    pop       = 1'b0;
    if (advance) begin
      valid_nxt           = 1'b1;
      beat_nxt.out_byte   = sel_byte;
      beat_nxt.run_last   = final_byte && head.run_last;
      beat_nxt.string_end = final_byte && head.string_end;
      pop                 = final_byte;
      phase_nxt           = final_byte ? 2'd0 : phase_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = beat_r;

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
    if (!rst_n) begin
      phase_r <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

@@ design/url_percent_escape_encoder.sv @@
// url percent-escape encoder
// input channel in_valid/in_ready/in_data carries one raw byte per beat, with
// in_last on the final byte of a string. output channel out_valid/out_ready/
// out_data carries one encoded byte per beat; run_last flags the last byte
// that an input beat caused, string_end the final byte of the string.
// a byte is decided once the two bytes after it are seen, so the first two
// input beats of a string give no output; in_last flushes the window.
// a decided byte is written into the queue and then into the output register
// before it is shown on out_valid; the output register moves one byte per
// cycle while out_ready lets it and the queue is not empty, so a passed byte
// gives one output beat and an escaped byte three; after a last beat the front
// pushes each held byte into the queue before it takes new input.
// the front stalls in_ready only when the decision queue is full or during
// the flush; the back stalls when out_ready is low and holds its beat.
// reset (rst_n low, synchronous) empties the window, the queue and the
// output register; no beat is shown until new input arrives.
module url_percent_escape_encoder #(
  parameter int QDEPTH = uep_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uep_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output uep_pkg::out_beat_t  out_data
);

  // front to queue
  logic               push_valid;
  uep_pkg::q_entry_t  push_entry;

  // queue to back
  uep_pkg::q_entry_t  head;
  uep_pkg::q_status_t q_status;
  logic               pop;

  // window and classification
  uep_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // decided bytes waiting for expansion
  uep_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // expansion to one or three output bytes
  uep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/uep_checker.sv @@
`include "assert_macros.svh"

module uep_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input uep_pkg::out_beat_t out_data
);

  logic byte_ok;

  // every output byte is alphanumeric, high, or a percent sign
  assign byte_ok = uep_pkg::is_alnum_or_high(out_data.out_byte) ||
                   (out_data.out_byte == uep_pkg::PERCENT_CHAR);

  `UEP_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid, "output beat dropped")
  `UEP_ASSERT(a_end_is_run_last, out_valid && out_data.string_end |-> out_data.run_last, "end without run_last")
  `UEP_ASSERT(a_byte_set, out_valid |-> byte_ok, "output byte outside escaped set")
  `UEP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind url_percent_escape_encoder uep_checker u_checker (.*);

@@ dv/tb_url_percent_escape_encoder.sv @@
module tb_url_percent_escape_encoder;

  // cycles with no beat on either channel before the run is abandoned
  localparam int IDLE_LIMIT   = 2000;
  // quiet cycles after the last expected beat, to catch stray output
  localparam int DRAIN_CYCLES = 20;
  // lower bound on raw bytes queued: directed part plus about 210 random ones
  localparam int TOTAL_CHARS  = 234;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PATTERN,
    RX_LONG_STALL
  } rx_mode_t;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  uep_pkg::in_beat_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  uep_pkg::out_beat_t out_data;

  url_percent_escape_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // raw bytes waiting to be sent, and escaped bytes still owed by the block
  uep_pkg::in_beat_t  pending_chars[$];
  uep_pkg::out_beat_t escaped_due[$];

  // shadow of the lookahead window
  logic [7:0] win_old;
  logic [7:0] win_new;
  logic [1:0] win_fill;

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  in_took     = 1'b0;
  bit  out_took    = 1'b0;

  // sender burst state
  int  burst_left = 4;
  int  gap_left   = 0;

  // receiver stall state
  rx_mode_t rx_mode    = RX_ALWAYS;
  int       rx_cycle   = 0;
  int       stall_left = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // letters, digits and everything from 0x7f up go out as they are
  function automatic logic passes_plain(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || (c >= uep_pkg::HIGH_START);
  endfunction

  function automatic logic hex_ascii(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
           (c >= "a" && c <= "f");
  endfunction

  // upper-case hex digit for one nibble
  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h41 + {4'h0, n} - 8'd10);
  endfunction

  function automatic void owe_byte(input logic [7:0] b);
    uep_pkg::out_beat_t o;
    o.out_byte   = b;
    o.run_last   = 1'b0;
    o.string_end = 1'b0;
    escaped_due.push_back(o);
  endfunction

  // decide one held byte; follow_ok says two following bytes exist
  function automatic void decide_char(input logic [7:0] c, input logic follow_ok,
                                      input logic [7:0] f1, input logic [7:0] f2);
    if (passes_plain(c)) begin
      owe_byte(c);
    end else if (c == uep_pkg::PERCENT_CHAR && follow_ok && hex_ascii(f1) &&
                 hex_ascii(f2)) begin
      // already a valid escape, keep it
      owe_byte(c);
    end else begin
      owe_byte(uep_pkg::PERCENT_CHAR);
      owe_byte(nibble_ascii(c[7:4]));
      owe_byte(nibble_ascii(c[3:0]));
    end
  endfunction

  // advance the window by one raw byte and queue what it decides
  function automatic void escape_char(input uep_pkg::in_beat_t b);
    int                 owed_before;
    uep_pkg::out_beat_t tail;
    owed_before = escaped_due.size();
    if (win_fill >= 2'd2) begin
      decide_char(win_old, 1'b1, win_new, b.in_byte);
      win_old  = win_new;
      win_new  = b.in_byte;
      win_fill = 2'd2;
    end else if (win_fill == 2'd1) begin
      win_new  = b.in_byte;
      win_fill = 2'd2;
    end else begin
      win_old  = b.in_byte;
      win_fill = 2'd1;
    end
    if (b.in_last) begin
      // flush: nothing follows, so a trailing percent gets escaped
      decide_char(win_old, 1'b0, 8'h00, 8'h00);
      if (win_fill >= 2'd2) decide_char(win_new, 1'b0, 8'h00, 8'h00);
      win_old  = 8'h00;
      win_new  = 8'h00;
      win_fill = 2'd0;
    end
    if (escaped_due.size() > owed_before) begin
      tail = escaped_due.pop_back();
      tail.run_last = 1'b1;
      if (b.in_last) tail.string_end = 1'b1;
      escaped_due.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_char(input logic [7:0] b, input logic last);
    uep_pkg::in_beat_t t;
    t.in_byte = b;
    t.in_last = last;
    pending_chars.push_back(t);
  endtask

  // whole text as one run; closes the string when ends_string is set
  task automatic queue_text(input string s, input logic ends_string);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], ends_string && (i == s.len() - 1));
    end
  endtask

  // byte mix that favors escapes and near-escapes
  function automatic logic [7:0] pick_char();
    string hexes;
    int    sel;
    hexes = "0123456789abcdefABCDEF";
    sel   = $urandom_range(0, 9);
    if (sel < 3) begin
      case ($urandom_range(0, 2))
        0:       return 8'($urandom_range(8'h41, 8'h5a));
        1:       return 8'($urandom_range(8'h61, 8'h7a));
        default: return 8'($urandom_range(8'h30, 8'h39));
      endcase
    end else if (sel < 5) begin
      return uep_pkg::PERCENT_CHAR;
    end else if (sel < 8) begin
      return hexes[$urandom_range(0, hexes.len() - 1)];
    end else begin
      return 8'($urandom_range(0, 255));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of beats separated by random gaps, inputs move on negedge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic               nxt_valid;
    uep_pkg::in_beat_t  nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_took) begin
      // previous beat gone (or none), free to pick the next one
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_chars.size() > 0) begin
        nxt_data  = pending_chars.pop_front();
        nxt_valid = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          // a quarter of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall style re-picked at random, out_ready set anew on all cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:  rdy = 1'b1;
      RX_COIN:    rdy = 1'($urandom_range(0, 1));
      RX_PATTERN: rdy = (rx_cycle % 7) < 3;
      default: begin
        // long stalls now and then
        if (stall_left > 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 20);
          rdy = 1'b1;
        end
      end
    endcase
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // monitor, checker and watchdog, all on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    uep_pkg::out_beat_t want;
    in_took  = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;

    if (!rst_n) begin
      win_old  = 8'h00;
      win_new  = 8'h00;
      win_fill = 2'd0;
    end

    if (in_took) escape_char(in_data);

    if (out_took) begin
      if (escaped_due.size() == 0) begin
        $error("unexpected output beat: out_byte %h run_last %b string_end %b",
               out_data.out_byte, out_data.run_last, out_data.string_end);
        error_count++;
      end else begin
        want = escaped_due.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
          error_count++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last: expected %b, actual %b", want.run_last, out_data.run_last);
          error_count++;
        end
        if (out_data.string_end !== want.string_end) begin
          $error("string_end: expected %b, actual %b", want.string_end,
                 out_data.string_end);
          error_count++;
        end
      end
    end

    // watchdog on cycles where neither channel moves a beat
    if (rst_n) begin
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no beat for %0d cycles, %0d expected beats outstanding",
               IDLE_LIMIT, escaped_due.size());
        $display("FAIL url_percent_escape_encoder");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int str_len;
    bit noise;

    // directed: lone zero byte, a two-byte string at the top of the range
    queue_char(8'h00, 1'b1);
    queue_char(8'hff, 1'b0);
    queue_char(8'h7f, 1'b1);
    // good escapes in both cases, one completed by the final byte
    queue_text("%4a%fF", 1'b1);
    // broken escape, then a percent at the very end
    queue_text("%G1%", 1'b1);
    // percent with only one byte after it
    queue_text("%9", 1'b1);
    // class boundaries around letters and digits, then 0x7e / 0x80
    queue_text("@[", 1'b0);
    queue_char(8'h60, 1'b0);
    queue_text("{/:Z", 1'b0);
    queue_char(8'h7e, 1'b0);
    queue_char(8'h80, 1'b1);

    // random strings; mostly short, some single byte, some pure noise
    while (pending_chars.size() < TOTAL_CHARS) begin
      str_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                            : $urandom_range(3, 12);
      noise   = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < str_len; i++) begin
        queue_char(noise ? 8'($urandom_range(0, 255)) : pick_char(),
                   i == str_len - 1);
      end
    end

    // reset held low from the start, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all raw bytes taken, then every owed byte seen, then a quiet spell
    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (escaped_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (escaped_due.size() != 0) begin
      $error("%0d expected beats never arrived", escaped_due.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("PASS url_percent_escape_encoder");
    end else begin
      $display("FAIL url_percent_escape_encoder");
    end
    $finish;
  end

endmodule
